### rtl/sine_beep_with_envelope_unit_defines.svh
// Assertion macros for the sine beep unit
`ifndef SINE_BEEP_WITH_ENVELOPE_UNIT_DEFINES_SVH
`define SINE_BEEP_WITH_ENVELOPE_UNIT_DEFINES_SVH

// Check cons in the same cycle as ante
`define SBE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante
`define SBE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sbe_pkg.sv
package sbe_pkg;

    localparam int PHASE_STEP_W = 24;
    localparam int COUNT_W      = 16;
    localparam int ENV_W        = 17;
    localparam int AMP_W        = 8;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 24;
    localparam int SAMPLE_W     = 16;
    localparam int MUL_A_W      = 32;
    localparam int PROD_W       = 40;

    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DURATION   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ATTACK     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ATTACK_STEP = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_DECAY_STEP = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_AMPLITUDE  = 3'd5;

    localparam logic [COUNT_W-1:0] ATTACK_RESET    = 16'd480;
    localparam logic [AMP_W-1:0]   AMPLITUDE_RESET = 8'd64;
    localparam logic [ENV_W-1:0]   ENV_ONE         = 17'd65536;

    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] SIN_C1  = 64'd1686629713;
    localparam logic [63:0] SIN_C3  = 64'd693598668;
    localparam logic [63:0] SIN_C5  = 64'd85569306;
    localparam logic [63:0] SIN_C7  = 64'd5026995;
    localparam logic [63:0] SIN_C9  = 64'd172272;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR,
        ST_MUL1,
        ST_MUL2,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [PHASE_STEP_W-1:0] phase_step;
        logic [COUNT_W-1:0]      duration_samples;
        logic [COUNT_W-1:0]      attack_samples;
        logic [ENV_W-1:0]        attack_step;
        logic [ENV_W-1:0]        decay_step;
        logic [AMP_W-1:0]        amplitude;
    } cfg_t;

    typedef struct packed {
        logic               en;
        logic [MUL_A_W-1:0] a;
        logic [ENV_W-1:0]   b;
    } mul_req_t;

    // Sine of a Q32 phase fraction, scaled to 32767 and rounded
    function automatic logic signed [SAMPLE_W-1:0] sine_from_h(input logic [63:0] h_in);
        logic [63:0] h;
        logic [63:0] u2;
        logic [63:0] s;
        logic [63:0] sn;
        logic [63:0] v;
        logic        neg;
        h   = h_in;
        neg = 1'b0;
        if (h >= 2 * Q30_ONE)
        begin
            neg = 1'b1;
            h   = h - 2 * Q30_ONE;
        end
        if (h > Q30_ONE)
        begin
            h = 2 * Q30_ONE - h;
        end
        u2 = (h * h) >> 30;
        s  = SIN_C9;
        s  = SIN_C7 - ((u2 * s) >> 30);
        s  = SIN_C5 - ((u2 * s) >> 30);
        s  = SIN_C3 - ((u2 * s) >> 30);
        s  = SIN_C1 - ((u2 * s) >> 30);
        sn = (h * s) >> 30;
        if (sn > Q30_ONE)
        begin
            sn = Q30_ONE;
        end
        v = (sn * 64'd32767 + (Q30_ONE >> 1)) >> 30;
        return neg ? SAMPLE_W'(64'd0 - v) : SAMPLE_W'(v);
    endfunction

    // Envelope for sample n given the previous envelope
    function automatic logic [ENV_W-1:0] env_for(input logic [COUNT_W-1:0] n,
                                                  input logic [ENV_W-1:0]   prev,
                                                  input cfg_t               cfg);
        logic [ENV_W:0] sum;
        sum = {1'b0, prev} + {1'b0, cfg.attack_step};
        if (n < cfg.attack_samples)
        begin
            if (n == '0)
            begin
                return '0;
            end
            return (sum > {1'b0, ENV_ONE}) ? ENV_ONE : sum[ENV_W-1:0];
        end
        if (n == cfg.attack_samples)
        begin
            return ENV_ONE;
        end
        return (prev > cfg.decay_step) ? (prev - cfg.decay_step) : '0;
    endfunction

endpackage

### rtl/sbe_cfg.sv
module sbe_cfg
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [sbe_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [sbe_pkg::CFG_DATA_W-1:0]         cfg_data,
    output sbe_pkg::cfg_t                          cfg
);

    sbe_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step       <= '0;
            cfg_reg.duration_samples <= '0;
            cfg_reg.attack_samples   <= sbe_pkg::ATTACK_RESET;
            cfg_reg.attack_step      <= '0;
            cfg_reg.decay_step       <= '0;
            cfg_reg.amplitude        <= sbe_pkg::AMPLITUDE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                sbe_pkg::REG_PHASE_STEP:
                    cfg_reg.phase_step <= cfg_data;
                sbe_pkg::REG_DURATION:
                    cfg_reg.duration_samples <= cfg_data[sbe_pkg::COUNT_W-1:0];
                sbe_pkg::REG_ATTACK:
                    cfg_reg.attack_samples <= cfg_data[sbe_pkg::COUNT_W-1:0];
                sbe_pkg::REG_ATTACK_STEP:
                    cfg_reg.attack_step <= cfg_data[sbe_pkg::ENV_W-1:0];
                sbe_pkg::REG_DECAY_STEP:
                    cfg_reg.decay_step <= cfg_data[sbe_pkg::ENV_W-1:0];
                sbe_pkg::REG_AMPLITUDE:
                    cfg_reg.amplitude <= cfg_data[sbe_pkg::AMP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/sbe_rom.sv
module sbe_rom
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic                                 clk,
    input  logic [ADDR_W-1:0]                    addr,
    output logic signed [sbe_pkg::SAMPLE_W-1:0]  data
);

    logic signed [sbe_pkg::SAMPLE_W-1:0] tab [DEPTH];
    logic signed [sbe_pkg::SAMPLE_W-1:0] data_reg;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_tab
        localparam logic [63:0] H = (64'(k) << 32) / DEPTH;
        assign tab[k] = sbe_pkg::sine_from_h(H);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= tab[addr];
    end

    assign data = data_reg;

endmodule

### rtl/sbe_mul.sv
module sbe_mul
(
    input  logic                             clk,
    input  sbe_pkg::mul_req_t                req,
    output logic [sbe_pkg::PROD_W-1:0]       prod
);

    localparam int FULL_W = sbe_pkg::MUL_A_W + sbe_pkg::ENV_W;

    logic [FULL_W-1:0]          full;
    logic [sbe_pkg::PROD_W-1:0] prod_reg;
    logic [sbe_pkg::PROD_W-1:0] prod_next;

    assign full      = FULL_W'(req.a) * FULL_W'(req.b);
    assign prod_next = req.en ? full[sbe_pkg::PROD_W-1:0] : prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

### rtl/sine_beep_with_envelope_unit.sv
// Sine beep generator with linear attack and decay envelope.
// Request channel s_*: one request per sample tick; s_tdata[0] = restart.
// A restart begins a new beep at sample zero; a tick with no beep running
// and no restart yields no result, as does a restart with zero duration.
// Result channel m_*: m_tdata is the signed 16-bit sample, m_tlast marks
// the final sample of the beep.
// Configuration: write cfg_data to register cfg_addr when cfg_we is high,
// only while no request is in flight. Registers 0..5: phase step, duration,
// attack samples, attack step, decay step, amplitude.
// Each request passes through ADDR, MUL1, MUL2 and OUT; no new request is
// taken until the last one is done: a registered sine ROM read, then two
// passes through one shared multiplier (sine times envelope, then times
// amplitude), then saturation into the output register.
// s_tready is high only while the sequencer is idle. When m_tready is low,
// the result stays in the output register; one more request may be taken
// and worked on, and its result waits until the register frees.
// Reset: asynchronous, clears the beep state, output valid and registers to
// their defaults; the sine ROM is constant and needs no fill time.
module sine_beep_with_envelope_unit
#(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int PHASE_BITS       = 24
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [7:0]                            s_tdata,   // [0] restart
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [sbe_pkg::SAMPLE_W-1:0]          m_tdata,   // [15:0] sample_value
    output logic                                  m_tlast,
    input  logic                                  cfg_we,
    input  logic [sbe_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [sbe_pkg::CFG_DATA_W-1:0]        cfg_data
);

    `include "sine_beep_with_envelope_unit_defines.svh"

    localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
    localparam int IPROD_W = PHASE_BITS + IDX_W + 1;
    localparam int CNT_W   = sbe_pkg::COUNT_W;
    localparam int ENV_W   = sbe_pkg::ENV_W;
    localparam int SMP_W   = sbe_pkg::SAMPLE_W;

    sbe_pkg::cfg_t     cfg;
    sbe_pkg::mul_req_t mul_req;
    sbe_pkg::state_t   state_reg;
    sbe_pkg::state_t   state_next;

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [PHASE_BITS-1:0]  phase_reg;
    logic [PHASE_BITS-1:0]  phase_next;
    logic [ENV_W-1:0]       env_reg;
    logic [ENV_W-1:0]       env_next;
    logic                   active_reg;
    logic                   active_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [SMP_W-1:0]       out_value_reg;
    logic                   out_last_reg;
    logic                   out_load;

    logic [IPROD_W-1:0]              idx_prod;
    logic [IDX_W:0]                  idx_full;
    logic [IDX_W-1:0]                rom_addr;
    logic signed [SMP_W-1:0]         rom_data;
    logic [SMP_W-1:0]                sine_abs;
    logic [sbe_pkg::PROD_W-1:0]      prod;
    logic [sbe_pkg::MUL_A_W-1:0]     mag;
    logic [SMP_W-1:0]                sat_value;
    logic                            sat_last;
    logic                            restart;

    sbe_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    assign idx_prod = IPROD_W'(phase_reg) * IPROD_W'(SINE_TABLE_DEPTH);
    assign idx_full = idx_prod[IPROD_W-1:PHASE_BITS];
    assign rom_addr = (idx_full >= (IDX_W+1)'(SINE_TABLE_DEPTH)) ?
                      IDX_W'(SINE_TABLE_DEPTH - 1) : idx_full[IDX_W-1:0];

    sbe_rom
    #(
        .DEPTH (SINE_TABLE_DEPTH)
    )
    u_rom
    (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    sbe_mul u_mul
    (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    assign restart  = s_tdata[0];
    assign sine_abs = rom_data[SMP_W-1] ? (SMP_W'(0) - rom_data) : rom_data;
    assign mag      = prod[sbe_pkg::PROD_W-1:8];
    assign sat_last = ({1'b0, count_reg} + (CNT_W+1)'(1)) >= {1'b0, cfg.duration_samples};

    always_comb
    begin
        if (rom_data[SMP_W-1])
        begin
            sat_value = (mag > 32'd32768) ? 16'h8000 : (SMP_W'(0) - mag[SMP_W-1:0]);
        end
        else
        begin
            sat_value = (mag > 32'd32767) ? 16'h7fff : mag[SMP_W-1:0];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        phase_next  = phase_reg;
        env_next    = env_reg;
        active_next = active_reg;
        mul_req     = '0;
        out_load    = 1'b0;
        case (state_reg)
            sbe_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (restart)
                    begin
                        count_next  = '0;
                        phase_next  = '0;
                        env_next    = sbe_pkg::env_for('0, '0, cfg);
                        active_next = (cfg.duration_samples != '0);
                        if (cfg.duration_samples != '0)
                        begin
                            state_next = sbe_pkg::ST_ADDR;
                        end
                    end
                    else if (active_reg)
                    begin
                        state_next = sbe_pkg::ST_ADDR;
                    end
                end
            end
            sbe_pkg::ST_ADDR:
            begin
                state_next = sbe_pkg::ST_MUL1;
            end
            sbe_pkg::ST_MUL1:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = sbe_pkg::MUL_A_W'(sine_abs);
                mul_req.b  = env_reg;
                state_next = sbe_pkg::ST_MUL2;
            end
            sbe_pkg::ST_MUL2:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = prod[sbe_pkg::MUL_A_W-1:0];
                mul_req.b  = ENV_W'(cfg.amplitude);
                state_next = sbe_pkg::ST_OUT;
            end
            sbe_pkg::ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = sbe_pkg::ST_IDLE;
                    if (sat_last)
                    begin
                        active_next = 1'b0;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                        phase_next = phase_reg + PHASE_BITS'(cfg.phase_step);
                        env_next   = sbe_pkg::env_for(count_reg + CNT_W'(1), env_reg, cfg);
                    end
                end
            end
            default:
            begin
                state_next = sbe_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbe_pkg::ST_IDLE;
            count_reg     <= '0;
            phase_reg     <= '0;
            env_reg       <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            phase_reg     <= phase_next;
            env_reg       <= env_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg <= sat_value;
            out_last_reg  <= sat_last;
        end
    end

    assign s_tready = (state_reg == sbe_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tlast  = out_last_reg;

    `SBE_ASSERT_NOW(a_env_cap, 1'b1, env_reg <= sbe_pkg::ENV_ONE,
        "envelope above unity")
    `SBE_ASSERT_NEXT(a_last_ends_beep, out_load && sat_last, !active_reg,
        "beep still active after last sample")
    `SBE_ASSERT_NOW(a_out_from_seq, $rose(m_tvalid), $past(state_reg) == sbe_pkg::ST_OUT,
        "result raised outside output state")
    `SBE_ASSERT_NEXT(a_idle_tick, s_tvalid && s_tready && !restart && !active_reg,
        state_reg == sbe_pkg::ST_IDLE, "idle tick started work")

endmodule
